// ===== rtl/ctwl_pkg.sv =====
// shared types, constants and the divider step of the ct window/level mapper
package ctwl_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PARAM_W     = 16;
  localparam int unsigned CALC_W      = PARAM_W + 2;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned DIV_STEPS   = CHAN_W / DIV_STAGES;

  localparam logic [IDX_W-1:0] REG_CENTER    = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [IDX_W-1:0] REG_SEG_EN    = 2'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

  // flags that ride along with the quotient
  typedef struct packed {
    logic seg;
    logic lo;
    logic hi;
  } ctl_t;

  // restoring divider state: control flags, partial remainder, dividend bits left, quotient
  typedef struct packed {
    ctl_t              ctl;
    logic [PARAM_W-1:0] rem;
    logic [CHAN_W-1:0]  dl;
    logic [CHAN_W-1:0]  quo;
  } div_t;

  // one radix-2 step against the window width
  function automatic div_t div_step(input div_t s, input logic [PARAM_W-1:0] w);
    div_t             r;
    logic [PARAM_W:0] t;
    logic [PARAM_W:0] diff;
    r    = s;
    t    = {s.rem, s.dl[CHAN_W-1]};
    diff = t - {1'b0, w};
    if (t >= {1'b0, w}) begin
      r.rem = diff[PARAM_W-1:0];
      r.quo = {s.quo[CHAN_W-2:0], 1'b1};
    end else begin
      r.rem = t[PARAM_W-1:0];
      r.quo = {s.quo[CHAN_W-2:0], 1'b0};
    end
    r.dl = {s.dl[CHAN_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

// ===== rtl/ct_window_level_with_threshold_mask.sv =====
// ct window/level grey mapper with magenta threshold overlay, pipelined
//
// usage:
//  - slave stream s_axis_*: one signed voxel sample per beat, raster order
//  - master stream m_axis_*: one rgba pixel per beat, same order, one per sample
//  - cfg port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 center, 1 width, 2 segmentation enable, 3 threshold); write only
//    while the pipeline is empty
//  - each accepted sample passes the front, scaling, divider and output stages
//  - throughput: one pixel per clock unless stalled; the 255*n/width quotient
//    is built by a restoring divider spread over four stages, two quotient bits each
//  - a stalled receiver holds the output beat; each stage keeps its beat
//    until the next stage frees up, so bubbles close and nothing is lost
//  - reset empties the pipeline and loads center 40, width 400,
//    segmentation off, threshold 0
//  - a segmented pixel comes out as 255,0,255,255 with tuser set
module ct_window_level_with_threshold_mask (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: sample[15:0]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ctwl_pkg::SAMPLE_W-1:0] s_axis_tdata,
  // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [4*ctwl_pkg::CHAN_W-1:0] m_axis_tdata,
  // tuser: segmented[0]
  output logic                         m_axis_tuser,
  input  logic                         cfg_we_i,
  input  logic [ctwl_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [ctwl_pkg::PARAM_W-1:0] cfg_wdata_i
);
  import ctwl_pkg::*;

  // stage 0 front compare, stage 1 scaling, stages 2..5 divider, stage 6 output
  localparam int unsigned NSTG = DIV_STAGES + 3;

  // configuration registers
  logic signed [PARAM_W-1:0] center_q;
  logic        [PARAM_W-1:0] width_q;
  logic                      seg_en_q;
  logic signed [PARAM_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 16'sd40;
      width_q  <= 16'd400;
      seg_en_q <= 1'b0;
      thresh_q <= 16'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER:    center_q <= cfg_wdata_i;
        REG_WIDTH:     width_q  <= cfg_wdata_i;
        REG_SEG_EN:    seg_en_q <= cfg_wdata_i[0];
        REG_THRESHOLD: thresh_q <= cfg_wdata_i;
      endcase
    end
  end

  // per-stage valid and load enables
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vin;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin = {vld_q[NSTG-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];

  // stage 0: window limits, threshold compare, offset into the window
  logic signed [CALC_W-1:0] smp;
  logic signed [CALC_W-1:0] half;
  logic signed [CALC_W-1:0] ctr;
  logic signed [CALC_W-1:0] thr;
  logic signed [CALC_W-1:0] lo_lim;
  logic signed [CALC_W-1:0] hi_lim;
  logic signed [CALC_W-1:0] offs;
  ctl_t                     ctl0_d;
  ctl_t                     ctl0_q;
  logic [PARAM_W-1:0]       offs_q;

  always_comb begin
    smp    = CALC_W'(signed'(s_axis_tdata[SAMPLE_BITS-1:0]));
    half   = signed'({3'b000, width_q[PARAM_W-1:1]});
    ctr    = CALC_W'(center_q);
    thr    = CALC_W'(thresh_q);
    lo_lim = ctr - half;
    hi_lim = ctr + half;
    offs   = smp - lo_lim;
    ctl0_d.seg = seg_en_q && (smp > thr);
    ctl0_d.lo  = smp <= lo_lim;
    ctl0_d.hi  = smp >= hi_lim;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      ctl0_q <= ctl0_d;
      offs_q <= offs[PARAM_W-1:0];
    end
  end

  // stage 1: dividend 255*n = (n << 8) - n, split into remainder seed and low bits
  div_t                        div_q [DIV_STAGES+1];
  logic [PARAM_W+CHAN_W-1:0]   dvd;
  div_t                        div0_d;

  always_comb begin
    dvd        = {offs_q, CHAN_ZERO} - {{CHAN_W{1'b0}}, offs_q};
    div0_d.ctl = ctl0_q;
    div0_d.rem = dvd[PARAM_W+CHAN_W-1:CHAN_W];
    div0_d.dl  = dvd[CHAN_W-1:0];
    div0_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      div_q[0] <= div0_d;
    end
  end

  // stages 2..5: two quotient bits per stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    div_t nxt;
    always_comb begin
      nxt = div_q[j];
      for (int s = 0; s < DIV_STEPS; s++) begin
        nxt = div_step(nxt, width_q);
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[j+2] && vin[j+2]) begin
        div_q[j+1] <= nxt;
      end
    end
  end

  // stage 6: colour select into the output register
  div_t              last;
  logic [CHAN_W-1:0] grey;
  logic [CHAN_W-1:0] red_d, green_d, blue_d;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              seg_q;

  always_comb begin
    last = div_q[DIV_STAGES];
    if (last.ctl.lo) begin
      grey = CHAN_ZERO;
    end else if (last.ctl.hi) begin
      grey = CHAN_MAX;
    end else begin
      grey = last.quo;
    end
    if (last.ctl.seg) begin
      red_d   = CHAN_MAX;
      green_d = CHAN_ZERO;
      blue_d  = CHAN_MAX;
    end else begin
      red_d   = grey;
      green_d = grey;
      blue_d  = grey;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1] && vin[NSTG-1]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      seg_q   <= last.ctl.seg;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {CHAN_MAX, blue_q, green_q, red_q};
  assign m_axis_tuser  = seg_q;

endmodule

// ===== rtl/ctwl_checker.sv =====
// port-level checks on the pixel stream of the window/level mapper
module ctwl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [4*ctwl_pkg::CHAN_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import ctwl_pkg::*;

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed under stall");

  // alpha is always opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4*CHAN_W-1:3*CHAN_W] == CHAN_MAX)
    else $error("alpha not opaque");

  // segmented pixels are magenta
  a_magenta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[CHAN_W-1:0] == CHAN_MAX &&
      m_axis_tdata[2*CHAN_W-1:CHAN_W] == CHAN_ZERO &&
      m_axis_tdata[3*CHAN_W-1:2*CHAN_W] == CHAN_MAX)
    else $error("segmented pixel not magenta");

  // unsegmented pixels are grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[CHAN_W-1:0] == m_axis_tdata[2*CHAN_W-1:CHAN_W] &&
      m_axis_tdata[CHAN_W-1:0] == m_axis_tdata[3*CHAN_W-1:2*CHAN_W])
    else $error("grey pixel has unequal channels");

endmodule

bind ct_window_level_with_threshold_mask ctwl_checker u_ctwl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_top.sv =====
// testbench for the ct window/level mapper: stream stimulus, pixel prediction and checks
`timescale 1ns / 1ps

// one rgba pixel as it leaves the block, plus the overlay flag
typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       segmented;
} pixel_t;

class pixel_scoreboard;
  int          mismatches;
  int          center;
  int unsigned width;
  bit          seg_on;
  int          threshold;
  pixel_t      pixels_due[$];

  function new();
    mismatches = 0;
    center     = 40;
    width      = 400;
    seg_on     = 1'b0;
    threshold  = 0;
  endfunction

  function void load_reg(input logic [ctwl_pkg::IDX_W-1:0] idx,
                         input logic [ctwl_pkg::PARAM_W-1:0] val);
    case (idx)
      ctwl_pkg::REG_CENTER:    center = $signed(val);
      ctwl_pkg::REG_WIDTH:     width = val;
      ctwl_pkg::REG_SEG_EN:    seg_on = val[0];
      ctwl_pkg::REG_THRESHOLD: threshold = $signed(val);
      default: ;
    endcase
  endfunction

  // window/level grey or magenta overlay for one voxel
  function pixel_t map_voxel(input logic [ctwl_pkg::SAMPLE_W-1:0] smp);
    longint     x;
    longint     c;
    longint     half;
    logic [7:0] grey;
    pixel_t     p;
    x    = $signed(smp);
    c    = center;
    half = longint'(width >> 1);
    p.alpha = ctwl_pkg::CHAN_MAX;
    if (seg_on && x > threshold) begin
      p.red       = ctwl_pkg::CHAN_MAX;
      p.green     = ctwl_pkg::CHAN_ZERO;
      p.blue      = ctwl_pkg::CHAN_MAX;
      p.segmented = 1'b1;
    end else begin
      // zero and one width never get past the two clamps
      if (x <= c - half) grey = ctwl_pkg::CHAN_ZERO;
      else if (x >= c + half) grey = ctwl_pkg::CHAN_MAX;
      else grey = 8'((255 * (x - c + half)) / longint'(width));
      p.red       = grey;
      p.green     = grey;
      p.blue      = grey;
      p.segmented = 1'b0;
    end
    return p;
  endfunction

  function void note_sample(input logic [ctwl_pkg::SAMPLE_W-1:0] smp);
    pixels_due.push_back(map_voxel(smp));
  endfunction

  function void compare_channel(input string name, input int unsigned want,
                                input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_pixel(input logic [4*ctwl_pkg::CHAN_W-1:0] data, input logic seg);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      $error("pixel beat with no sample waiting: tdata %h tuser %b", data, seg);
      mismatches++;
    end else begin
      want = pixels_due.pop_front();
      compare_channel("red", want.red, data[7:0]);
      compare_channel("green", want.green, data[15:8]);
      compare_channel("blue", want.blue, data[23:16]);
      compare_channel("alpha", want.alpha, data[31:24]);
      compare_channel("segmented", want.segmented, seg);
    end
  endfunction

  function int pending();
    return pixels_due.size();
  endfunction
endclass

module tb_top;
  import ctwl_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: sample[15:0]
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic [4*CHAN_W-1:0]   m_axis_tdata;
  // tuser: segmented[0]
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [IDX_W-1:0]      cfg_idx_i = REG_CENTER;
  logic [PARAM_W-1:0]    cfg_wdata_i = '0;

  pixel_scoreboard       sb;
  logic [SAMPLE_W-1:0]   voxel_q[$];
  bit                    calm = 1'b0;   // no idling on either side while set
  int                    stall_left = 0;

  ct_window_level_with_threshold_mask dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // saturate to the signed 16-bit range
  function automatic logic [15:0] clamp16(input int v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7FFF;
    return v[15:0];
  endfunction

  // pixel side: check every accepted beat, then pick tready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_pixel(m_axis_tdata, m_axis_tuser);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      // start a burst of stalled cycles, this one included
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // block until every predicted pixel has come out
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [PARAM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.load_reg(idx, val);
  endtask

  // all four registers, only with the pipeline empty
  task automatic program_window(input logic [15:0] c, input logic [15:0] w,
                                input logic en, input logic [15:0] t);
    wait_drained();
    put_reg(REG_CENTER, c);
    put_reg(REG_WIDTH, w);
    put_reg(REG_SEG_EN, {15'b0, en});
    put_reg(REG_THRESHOLD, t);
    cfg_we_i <= 1'b0;
  endtask

  // push the queued voxels through the slave side, with random gaps
  task automatic stream_voxels();
    foreach (voxel_q[i]) begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= voxel_q[i];
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_sample(voxel_q[i]);
    end
    s_axis_tvalid <= 1'b0;
    voxel_q.delete();
  endtask

  initial begin
    int          ph;
    int          n;
    int          c;
    int          w;
    int          thr;
    int          v;
    logic [15:0] cw;
    logic [15:0] ww;
    logic [15:0] tw;
    logic        en;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window 40/400: full-scale extremes, both clamp edges, the center
    voxel_q = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFF60, 16'hFF61, 16'd239, 16'd240,
                16'd40};
    stream_voxels();

    // zero width: hard step around the center
    program_window(16'd0, 16'd0, 1'b0, 16'd0);
    voxel_q = '{16'hFFFF, 16'h0000, 16'h0001};
    stream_voxels();

    // width of one acts like zero width, center at the bottom
    program_window(16'h8000, 16'd1, 1'b0, 16'h7FFF);
    voxel_q = '{16'h8000, 16'h8001};
    stream_voxels();

    // widest window at the top center, overlay on but nothing above threshold
    program_window(16'h7FFF, 16'hFFFF, 1'b1, 16'h7FFF);
    voxel_q = '{16'h7FFF, 16'h0000, 16'h8000};
    stream_voxels();

    // lowest threshold: everything but the minimum is painted
    program_window(16'h8000, 16'hFFFF, 1'b1, 16'h8000);
    voxel_q = '{16'h8000, 16'h8001, 16'h7FFF};
    stream_voxels();

    // width two: one interpolated step, overlay off with a low threshold
    program_window(16'd0, 16'd2, 1'b0, 16'h8000);
    voxel_q = '{16'hFFFF, 16'h0000, 16'h0001};
    stream_voxels();

    // random phases, the last one short and without idling
    for (ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: cw = 16'h8000;
        1: cw = 16'h7FFF;
        2: cw = 16'($urandom);
        default: cw = clamp16(int'($urandom_range(0, 4000)) - 2000);
      endcase
      case ($urandom_range(0, 6))
        0: ww = 16'd0;
        1: ww = 16'd1;
        2: ww = 16'hFFFF;
        3: ww = 16'($urandom_range(2, 8));
        4: ww = 16'($urandom);
        default: ww = 16'($urandom_range(2, 1000));
      endcase
      en = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: tw = 16'h8000;
        1: tw = 16'h7FFF;
        default: tw = clamp16($signed(cw) + int'($urandom_range(0, 1000)) - 500);
      endcase
      program_window(cw, ww, en, tw);
      calm = (ph == 9) || ($urandom_range(0, 3) == 0);
      c   = $signed(cw);
      w   = ww;
      thr = $signed(tw);
      n   = (ph == 9) ? 100 : 200;
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: v = c - w / 2 - 4 + int'($urandom_range(0, w + 8));
          4, 5: v = thr - 2 + int'($urandom_range(0, 4));
          6: v = c - 2 + int'($urandom_range(0, 4));
          7: v = $urandom_range(0, 1) ? -32768 : 32767;
          default: v = $signed(16'($urandom));
        endcase
        voxel_q.push_back(clamp16(v));
      end
      stream_voxels();
    end

    // drain, then watch for stray beats before the verdict
    wait_drained();
    repeat (24) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
